// File: design/bqpmw_pkg.sv
// bqpmw_pkg: shared constants, codes and types of the block qp map writer
// used by bqpmw_ctrl, bqpmw_dp and block_qp_map_writer; depends on nothing
package bqpmw_pkg;

   // geometry limits
   localparam int MAX_COLS = 512;
   localparam int MAX_ROWS = 512;
   localparam int MAX_PAD  = 63;

   // field and register widths
   localparam int QP_IN_W = 8;
   localparam int QP_W    = 6;
   localparam int MODE_W  = 3;
   localparam int DIM_W   = 10;
   localparam int PAD_W   = 6;
   localparam int IDX_W   = 19;
   localparam int SUM_W   = 24;
   localparam int COL_W   = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 10;

   // divider sizing: area = cols * rows
   localparam int AREA_W   = 2 * DIM_W;
   localparam int REM_W    = AREA_W + 1;
   localparam int DIV_STEPS = SUM_W;
   localparam int DCNT_W   = $clog2(DIV_STEPS);

   // stream packing
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 48;

   // qp constants
   localparam logic [QP_W-1:0] QP_MIN  = QP_W'(1);
   localparam logic [QP_W-1:0] QP_MAX  = QP_W'(51);
   localparam logic [QP_W-1:0] QP_LOW  = QP_W'(24);
   localparam logic [QP_W-1:0] QP_HIGH = QP_W'(44);

   // mode codes
   localparam logic [MODE_W-1:0] MODE_MAP       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_FLAT_LOW  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FLAT_HIGH = 3'd2;
   localparam logic [MODE_W-1:0] MODE_CHECKER   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_CENTRE    = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_ROWS   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_PAD    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ANCHOR = 3'd4;

   // register reset values
   localparam logic [DIM_W-1:0] COLS_RST   = DIM_W'(1);
   localparam logic [DIM_W-1:0] ROWS_RST   = DIM_W'(1);
   localparam logic [QP_W-1:0]  ANCHOR_RST = QP_W'(26);

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DIM_W-1:0]  cols;
      logic [DIM_W-1:0]  rows;
      logic [PAD_W-1:0]  pad;
      logic [QP_W-1:0]   anchor;
   } cfg_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic div_step;
      logic emit_blk;
      logic emit_pad;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last_col;
      logic last_row;
      logic pad_zero;
      logic pad_last;
      logic div_last;
      logic slot_free;
   } stat_type;

endpackage

// File: design/bqpmw_ctrl.sv
// bqpmw_ctrl: sequencer for accept, frame-mean divide, block and padding results
// depends on bqpmw_pkg (cmd_type, stat_type)
module bqpmw_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  bqpmw_pkg::stat_type stat,
   output bqpmw_pkg::cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_BLK  = 2'd2;
   localparam logic [1:0] ST_PAD  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd.load     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.emit_blk = 1'b0;
      cmd.emit_pad = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = (stat.last_col && stat.last_row) ? ST_DIV : ST_BLK;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_BLK;
            end
         end
         ST_BLK: begin
            if (stat.slot_free) begin
               cmd.emit_blk = 1'b1;
               state_in = (stat.last_col && !stat.pad_zero) ? ST_PAD : ST_IDLE;
            end
         end
         ST_PAD: begin
            if (stat.slot_free) begin
               cmd.emit_pad = 1'b1;
               if (stat.pad_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: design/bqpmw_dp.sv
// bqpmw_dp: position, qp selection, statistics, mean divider and result register
// depends on bqpmw_pkg; commanded by bqpmw_ctrl
module bqpmw_dp (
   input  logic                                   clock,
   input  logic                                   reset,
   input  bqpmw_pkg::cfg_type                     cfg,
   input  logic [bqpmw_pkg::QP_IN_W-1:0]          qp_in,
   input  bqpmw_pkg::cmd_type                     cmd,
   output bqpmw_pkg::stat_type                    stat,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [bqpmw_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                   rsp_tlast,
   output logic                                   rsp_tuser
);

   localparam int DW = bqpmw_pkg::DIM_W;
   localparam int QW = bqpmw_pkg::QP_W;
   localparam int IW = bqpmw_pkg::IDX_W;
   localparam int SW = bqpmw_pkg::SUM_W;
   localparam int CW = bqpmw_pkg::COL_W;
   localparam int RW = bqpmw_pkg::ROW_W;
   localparam int PW = bqpmw_pkg::PAD_W;
   localparam int AW = bqpmw_pkg::AREA_W;
   localparam int MW = bqpmw_pkg::REM_W;
   localparam int NW = bqpmw_pkg::DCNT_W;

   // position and statistics
   logic [CW-1:0] col_pos_ff, col_pos_in;
   logic [RW-1:0] row_pos_ff, row_pos_in;
   logic [QW-1:0] run_min_ff, run_min_in;
   logic [QW-1:0] run_max_ff, run_max_in;
   logic [SW-1:0] run_sum_ff, run_sum_in;

   // per-item registers
   logic [QW-1:0] qp_ff;
   logic [IW-1:0] base_ff;
   logic [PW-1:0] k_ff;

   // divider
   logic [MW-1:0] rem_ff;
   logic [SW-1:0] quo_ff;
   logic [AW-1:0] area_ff;
   logic [NW-1:0] dcnt_ff;

   // result register
   logic          out_vld_ff;
   logic [IW-1:0] out_idx_ff;
   logic [QW-1:0] out_qp_ff;
   logic          out_last_ff;
   logic          out_done_ff;
   logic [QW-1:0] out_min_ff;
   logic [QW-1:0] out_max_ff;
   logic [QW-1:0] out_avg_ff;

   logic [DW-1:0]   cols;
   logic [DW-1:0]   rows;
   logic [PW-1:0]   pad;
   logic [DW:0]     pitch;
   logic [CW-1:0]   x;
   logic [RW-1:0]   y;
   logic [DW-1:0]   x0;
   logic [DW-1:0]   y0;
   logic            in_region;
   logic [bqpmw_pkg::QP_IN_W-1:0] qp_sel;
   logic [QW-1:0]   qp_new;
   logic [QW-1:0]   anchor_cl;
   logic [QW-1:0]   avg_cl;
   logic [MW-1:0]   rem_sh;
   logic            fits;
   logic            last_blk;
   logic            finish;
   logic            frame_end;
   logic            emit;
   logic            emit_last;
   logic [IW-1:0]   emit_idx;
   logic [QW-1:0]   emit_qp;

   // effective geometry
   always_comb begin
      if (cfg.cols == '0) begin
         cols = DW'(1);
      end else if (cfg.cols > DW'(bqpmw_pkg::MAX_COLS)) begin
         cols = DW'(bqpmw_pkg::MAX_COLS);
      end else begin
         cols = cfg.cols;
      end
      if (cfg.rows == '0) begin
         rows = DW'(1);
      end else if (cfg.rows > DW'(bqpmw_pkg::MAX_ROWS)) begin
         rows = DW'(bqpmw_pkg::MAX_ROWS);
      end else begin
         rows = cfg.rows;
      end
      pad   = (cfg.pad > PW'(bqpmw_pkg::MAX_PAD)) ? PW'(bqpmw_pkg::MAX_PAD) : cfg.pad;
      pitch = {1'b0, cols} + (DW + 1)'(pad);
      x     = (DW'(col_pos_ff) < cols) ? col_pos_ff : CW'(cols - DW'(1));
      y     = (DW'(row_pos_ff) < rows) ? row_pos_ff : RW'(rows - DW'(1));
   end

   // block qp from mode
   always_comb begin
      x0        = cols >> 2;
      y0        = rows >> 2;
      in_region = (DW'(x) >= x0) && (DW'(x) < cols - x0) &&
                  (DW'(y) >= y0) && (DW'(y) < rows - y0);
      case (cfg.mode)
         bqpmw_pkg::MODE_FLAT_LOW:  qp_sel = 8'(bqpmw_pkg::QP_LOW);
         bqpmw_pkg::MODE_FLAT_HIGH: qp_sel = 8'(bqpmw_pkg::QP_HIGH);
         bqpmw_pkg::MODE_CHECKER: begin
            qp_sel = (x[0] ^ y[0]) ? 8'(bqpmw_pkg::QP_HIGH) : 8'(bqpmw_pkg::QP_LOW);
         end
         bqpmw_pkg::MODE_CENTRE: begin
            qp_sel = in_region ? 8'(bqpmw_pkg::QP_LOW) : 8'(bqpmw_pkg::QP_HIGH);
         end
         default: qp_sel = qp_in;
      endcase
      if (qp_sel < 8'(bqpmw_pkg::QP_MIN)) begin
         qp_new = bqpmw_pkg::QP_MIN;
      end else if (qp_sel > 8'(bqpmw_pkg::QP_MAX)) begin
         qp_new = bqpmw_pkg::QP_MAX;
      end else begin
         qp_new = QW'(qp_sel);
      end
   end

   // padding qp and clamped mean
   always_comb begin
      if (cfg.anchor < bqpmw_pkg::QP_MIN) begin
         anchor_cl = bqpmw_pkg::QP_MIN;
      end else if (cfg.anchor > bqpmw_pkg::QP_MAX) begin
         anchor_cl = bqpmw_pkg::QP_MAX;
      end else begin
         anchor_cl = cfg.anchor;
      end
      if (quo_ff == '0) begin
         avg_cl = bqpmw_pkg::QP_MIN;
      end else if (quo_ff > SW'(bqpmw_pkg::QP_MAX)) begin
         avg_cl = bqpmw_pkg::QP_MAX;
      end else begin
         avg_cl = QW'(quo_ff);
      end
   end

   // status to the controller
   always_comb begin
      stat.last_col  = (DW'(x) == cols - DW'(1));
      stat.last_row  = (DW'(y) == rows - DW'(1));
      stat.pad_zero  = (pad == '0);
      stat.pad_last  = (k_ff == pad - PW'(1));
      stat.div_last  = (dcnt_ff == NW'(bqpmw_pkg::DIV_STEPS - 1));
      stat.slot_free = !out_vld_ff || rsp_tready;
   end

   // result selection and end-of-run detection
   always_comb begin
      last_blk  = !stat.last_col || stat.pad_zero;
      emit      = cmd.emit_blk || cmd.emit_pad;
      emit_last = (cmd.emit_blk && last_blk) || (cmd.emit_pad && stat.pad_last);
      finish    = emit_last;
      frame_end = stat.last_col && stat.last_row;
      if (cmd.emit_pad) begin
         emit_idx = base_ff + IW'(cols) + IW'(k_ff);
         emit_qp  = anchor_cl;
      end else begin
         emit_idx = base_ff + IW'(x);
         emit_qp  = qp_ff;
      end
   end

   // running statistics and position
   always_comb begin
      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      run_sum_in = run_sum_ff;
      col_pos_in = col_pos_ff;
      row_pos_in = row_pos_ff;
      if (cmd.load) begin
         run_min_in = (qp_new < run_min_ff) ? qp_new : run_min_ff;
         run_max_in = (qp_new > run_max_ff) ? qp_new : run_max_ff;
         run_sum_in = run_sum_ff + SW'(qp_new);
      end
      if (finish) begin
         if (frame_end) begin
            col_pos_in = '0;
            row_pos_in = '0;
            run_min_in = bqpmw_pkg::QP_MAX;
            run_max_in = bqpmw_pkg::QP_MIN;
            run_sum_in = '0;
         end else if (stat.last_col) begin
            col_pos_in = '0;
            row_pos_in = y + RW'(1);
         end else begin
            col_pos_in = x + CW'(1);
            row_pos_in = y;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
         run_min_ff <= bqpmw_pkg::QP_MAX;
         run_max_ff <= bqpmw_pkg::QP_MIN;
         run_sum_ff <= '0;
      end else begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
         run_sum_ff <= run_sum_in;
      end
   end

   // item registers: qp, row base (one multiply), padding column count
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         qp_ff   <= qp_new;
         base_ff <= IW'(y) * IW'(pitch);
      end
      if (cmd.emit_blk) begin
         k_ff <= '0;
      end else if (cmd.emit_pad) begin
         k_ff <= k_ff + PW'(1);
      end
   end

   // restoring divider, one quotient bit per step
   always_comb begin
      rem_sh = {rem_ff[MW-2:0], quo_ff[SW-1]};
      fits   = rem_sh >= MW'(area_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rem_ff  <= '0;
         quo_ff  <= run_sum_in;
         area_ff <= AW'(cols) * AW'(rows);
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= fits ? rem_sh - MW'(area_ff) : rem_sh;
         quo_ff  <= {quo_ff[SW-2:0], fits};
         dcnt_ff <= dcnt_ff + NW'(1);
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (emit) begin
         out_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_idx_ff  <= emit_idx;
         out_qp_ff   <= emit_qp;
         out_last_ff <= emit_last;
         out_done_ff <= emit_last && frame_end;
         out_min_ff  <= (emit_last && frame_end) ? run_min_ff : '0;
         out_max_ff  <= (emit_last && frame_end) ? run_max_ff : '0;
         out_avg_ff  <= (emit_last && frame_end) ? avg_cl : '0;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;
   assign rsp_tdata  = {(bqpmw_pkg::RSP_DATA_W - IW - 4 * QW)'(0),
                        out_avg_ff, out_max_ff, out_min_ff, out_qp_ff, out_idx_ff};

endmodule

// File: design/block_qp_map_writer.sv
// block_qp_map_writer: top level with configuration registers, sequencer and datapath
// depends on bqpmw_pkg, bqpmw_ctrl and bqpmw_dp
//
// Takes one qp item per block in raster order and writes a result item per block,
// then pad_cols padding items after each row's last block. An ordinary block is
// accepted, then loaded into the result register once that register is free to
// take it; each padding column adds a load of its own. The last block of a frame
// also runs the restoring divider that forms the frame mean, one quotient bit per cycle.
// A finished result waits in the result register while the next item is taken.
// The user must write registers only while the block is idle; the block does not enforce it.
module block_qp_map_writer (
   input  logic                                   clock,
   input  logic                                   reset,
   // request stream
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [bqpmw_pkg::REQ_DATA_W-1:0]       req_tdata,  // qp_in[7:0]
   // result stream
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // buf_index[18:0], buf_qp[24:19], min_qp[30:25], max_qp[36:31], avg_qp[42:37]
   output logic [bqpmw_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                   rsp_tlast,  // last_of_run
   output logic                                   rsp_tuser,  // frame_done
   // configuration writes
   input  logic                                   csr_we,
   input  logic [bqpmw_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bqpmw_pkg::CSR_DAT_W-1:0]        csr_wdata
);

   bqpmw_pkg::cfg_type  cfg_ff;
   bqpmw_pkg::cfg_type  cfg_in;
   bqpmw_pkg::cmd_type  cmd;
   bqpmw_pkg::stat_type stat;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            bqpmw_pkg::REG_MODE:   cfg_in.mode   = bqpmw_pkg::MODE_W'(csr_wdata);
            bqpmw_pkg::REG_COLS:   cfg_in.cols   = bqpmw_pkg::DIM_W'(csr_wdata);
            bqpmw_pkg::REG_ROWS:   cfg_in.rows   = bqpmw_pkg::DIM_W'(csr_wdata);
            bqpmw_pkg::REG_PAD:    cfg_in.pad    = bqpmw_pkg::PAD_W'(csr_wdata);
            bqpmw_pkg::REG_ANCHOR: cfg_in.anchor = bqpmw_pkg::QP_W'(csr_wdata);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode   <= bqpmw_pkg::MODE_MAP;
         cfg_ff.cols   <= bqpmw_pkg::COLS_RST;
         cfg_ff.rows   <= bqpmw_pkg::ROWS_RST;
         cfg_ff.pad    <= '0;
         cfg_ff.anchor <= bqpmw_pkg::ANCHOR_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   bqpmw_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bqpmw_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .qp_in      (req_tdata[bqpmw_pkg::QP_IN_W-1:0]),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
